FILE: src/min_heap_timer_queue_assert.svh
// assertion macros for the timer queue
// used by min_heap_timer_queue.sv, needs clk and rst in scope
`ifndef MIN_HEAP_TIMER_QUEUE_ASSERT_SVH
`define MIN_HEAP_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication
`define MHTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MHTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mhtq_pkg.sv
// shared types, codes and helpers of the timer queue
// no dependencies
package mhtq_pkg;

  localparam int KIND_W = 3;
  localparam int TID_W  = 10;
  localparam int TMO_W  = 31;
  localparam int EXP_W  = 32;
  localparam int RK_W   = 2;
  localparam int POP_W  = 6;
  localparam int MAX_POP = 32;

  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADJ   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FIRE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

  localparam logic [RK_W-1:0] RK_EXPIRED  = 2'd0;
  localparam logic [RK_W-1:0] RK_DEADLINE = 2'd1;
  localparam logic [RK_W-1:0] RK_DONE     = 2'd2;
  localparam logic [RK_W-1:0] RK_ERROR    = 2'd3;

  localparam logic signed [EXP_W-1:0] REM_NONE = -32'sd1;

  typedef struct packed {
    logic [TID_W-1:0] owner;
    logic [EXP_W-1:0] expiry;
  } heap_entry_t;

  // wrap-safe ordering: a before b
  function automatic logic earlier(input logic [EXP_W-1:0] a, input logic [EXP_W-1:0] b);
    logic [EXP_W-1:0] d;
    d = a - b;
    return d[EXP_W-1];
  endfunction

endpackage

FILE: src/mhtq_cmd_if.sv
// command channel of the timer queue
// depends on mhtq_pkg
interface mhtq_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [mhtq_pkg::KIND_W-1:0] kind;
  logic [mhtq_pkg::TID_W-1:0]  timer_id;
  logic [mhtq_pkg::TMO_W-1:0]  timeout_ms;

  modport source (output valid, kind, timer_id, timeout_ms, input ready);
  modport sink   (input valid, kind, timer_id, timeout_ms, output ready);
endinterface

FILE: src/mhtq_res_if.sv
// result channel of the timer queue
// depends on mhtq_pkg
interface mhtq_res_if;
  logic                             valid;
  logic                             ready;
  logic [mhtq_pkg::RK_W-1:0]        result_kind;
  logic [mhtq_pkg::TID_W-1:0]       expired_id;
  logic signed [mhtq_pkg::EXP_W-1:0] remaining_ms;
  logic                             last;

  modport source (output valid, result_kind, expired_id, remaining_ms, last, input ready);
  modport sink   (input valid, result_kind, expired_id, remaining_ms, last, output ready);
endinterface

FILE: src/min_heap_timer_queue.sv
// timer queue top level: binary min-heap in a memory, sequenced sift unit
// depends on mhtq_pkg, mhtq_cmd_if, mhtq_res_if, min_heap_timer_queue_assert.svh
// Timer queue keeping up to CAPACITY timers in a binary min-heap ordered on
// absolute expiry (wrap-safe 32-bit ms arithmetic). One command item is taken
// at a time; ready stays low until every result of the item has been handed
// to the output register. The heap and the id-to-slot table are memories with
// one read and one write port and registered reads; a sift-down step per heap
// level runs through S_SD_RC, S_SD_RC1 and S_SD_CMP, a sift-up step through
// S_SU and S_SU_CMP. An add or adjust sifts its timer into place, a fire
// removes its timer, a tick or query removes expired timers one at a time (at
// most MAX_POP per command). A clearing pass over every id-table entry after
// reset wipes the presence bits; no command is taken until it finishes.
`include "min_heap_timer_queue_assert.svh"

module min_heap_timer_queue #(
  parameter int CAPACITY = 32,
  parameter int ID_SPACE = 1024
) (
  input logic         clk,
  input logic         rst,
  mhtq_cmd_if.sink    cmd,
  mhtq_res_if.source  res
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int C_W    = SLOT_W + 2;
  localparam int ID_W   = $clog2(ID_SPACE);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOOK, S_DISP,
    S_SD_RC, S_SD_RC1, S_SD_CMP,
    S_SU, S_SU_CMP, S_PLACE,
    S_RM, S_RM_RD, S_RM_LD,
    S_POP, S_POP_CHK, S_FIN, S_FIN_EMIT
  } state_t;

  state_t state;

  // heap memory and id table (present bit on top of slot)
  mhtq_pkg::heap_entry_t hm [CAPACITY];
  logic [SLOT_W:0]       sm [ID_SPACE];

  mhtq_pkg::heap_entry_t hm_rd, hm_wdata;
  logic [SLOT_W-1:0]     hm_raddr, hm_waddr;
  logic                  hm_we;
  logic [SLOT_W:0]       sm_rd, sm_wdata;
  logic [ID_W-1:0]       sm_raddr, sm_waddr;
  logic                  sm_we;

  // command latch and working registers
  logic [mhtq_pkg::KIND_W-1:0] kind;
  logic [mhtq_pkg::TID_W-1:0]  tid;
  logic [mhtq_pkg::TMO_W-1:0]  tmo;
  logic [mhtq_pkg::EXP_W-1:0]  now;
  logic [CNT_W-1:0]            count;
  logic [SLOT_W-1:0]           i;
  logic [C_W-1:0]              c;
  logic                        moved;
  mhtq_pkg::heap_entry_t       cur;
  mhtq_pkg::heap_entry_t       ch;
  logic [mhtq_pkg::POP_W-1:0]  k;
  logic [mhtq_pkg::TID_W-1:0]  rid;
  logic [ID_W-1:0]             clr;

  // output register
  logic                              out_valid;
  logic [mhtq_pkg::RK_W-1:0]         out_kind;
  logic [mhtq_pkg::TID_W-1:0]        out_id;
  logic signed [mhtq_pkg::EXP_W-1:0] out_rem;
  logic                              out_last;

  // derived values
  logic [C_W-1:0]             c1;
  logic                       pick_right;
  mhtq_pkg::heap_entry_t      sel;
  logic [SLOT_W-1:0]          sel_idx;
  logic                       sd_stop, su_stop;
  logic [SLOT_W-1:0]          par;
  logic [mhtq_pkg::EXP_W-1:0] d;
  logic                       due;
  logic                       out_free;
  logic                       out_load;
  logic                       in_range, known;
  logic                       is_pop;
  logic [mhtq_pkg::EXP_W-1:0] new_exp;
  logic [ID_W-1:0]            id_idx;
  logic                       cmd_acc;

  assign cmd.ready  = (state == S_IDLE);
  assign cmd_acc    = cmd.valid && cmd.ready;
  assign res.valid        = out_valid;
  assign res.result_kind  = out_kind;
  assign res.expired_id   = out_id;
  assign res.remaining_ms = out_rem;
  assign res.last         = out_last;

  assign out_free = !out_valid || res.ready;
  assign c1       = c + C_W'(1);
  // right child only when it lies inside the heap and is strictly earlier
  assign pick_right = (c1 < C_W'(count)) && mhtq_pkg::earlier(hm_rd.expiry, ch.expiry);
  assign sel        = pick_right ? hm_rd : ch;
  assign sel_idx    = pick_right ? c1[SLOT_W-1:0] : c[SLOT_W-1:0];
  assign sd_stop    = mhtq_pkg::earlier(cur.expiry, sel.expiry);
  assign su_stop    = mhtq_pkg::earlier(hm_rd.expiry, cur.expiry);
  assign par        = (i - SLOT_W'(1)) >> 1;
  assign d          = hm_rd.expiry - now;
  assign due        = (d == '0) || d[mhtq_pkg::EXP_W-1];
  assign in_range   = 32'(tid) < 32'(ID_SPACE);
  assign known      = in_range && sm_rd[SLOT_W];
  assign is_pop     = (kind == mhtq_pkg::KIND_TICK) || (kind == mhtq_pkg::KIND_QUERY);
  assign new_exp    = now + {1'b0, tmo};
  assign id_idx     = ID_W'(tid);

  // a result item enters the output register this cycle
  always_comb begin
    out_load = 1'b0;
    case (state)
      S_DISP: begin
        if (known) begin
          out_load = (kind == mhtq_pkg::KIND_FIRE);
        end else if (kind != mhtq_pkg::KIND_FIRE) begin
          out_load = (kind == mhtq_pkg::KIND_ADJ) || !in_range ||
                     (count >= CNT_W'(CAPACITY));
        end
      end
      S_POP_CHK:  out_load = due;
      S_FIN_EMIT: out_load = 1'b1;
      default: ;
    endcase
    out_load = out_load && out_free;
  end

  // memory port control
  always_comb begin
    hm_raddr = '0;
    hm_we    = 1'b0;
    hm_waddr = i;
    hm_wdata = cur;
    sm_raddr = id_idx;
    sm_we    = 1'b0;
    sm_waddr = ID_W'(cur.owner);
    sm_wdata = {1'b1, i};
    case (state)
      S_CLR: begin
        sm_we    = 1'b1;
        sm_waddr = clr;
        sm_wdata = '0;
      end
      S_SD_RC:  hm_raddr = c[SLOT_W-1:0];
      S_SD_RC1: hm_raddr = c1[SLOT_W-1:0];
      S_SD_CMP: begin
        if (!sd_stop) begin
          hm_we    = 1'b1;
          hm_wdata = sel;
          sm_we    = 1'b1;
          sm_waddr = ID_W'(sel.owner);
        end
      end
      S_SU: hm_raddr = par;
      S_SU_CMP: begin
        if (!su_stop) begin
          hm_we    = 1'b1;
          hm_wdata = hm_rd;
          sm_we    = 1'b1;
          sm_waddr = ID_W'(hm_rd.owner);
        end
      end
      S_PLACE: begin
        hm_we = 1'b1;
        sm_we = 1'b1;
      end
      S_RM: begin
        sm_we    = 1'b1;
        sm_waddr = ID_W'(rid);
        sm_wdata = '0;
      end
      S_RM_RD: hm_raddr = SLOT_W'(count);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hm_we) begin
      hm[hm_waddr] <= hm_wdata;
    end
    hm_rd <= hm[hm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      sm[sm_waddr] <= sm_wdata;
    end
    sm_rd <= sm[sm_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      count     <= '0;
      now       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!out_load && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr <= clr + ID_W'(1);
          if (clr == ID_W'(ID_SPACE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_acc) begin
            kind <= cmd.kind;
            tid  <= cmd.timer_id;
            tmo  <= cmd.timeout_ms;
            k    <= '0;
            case (cmd.kind)
              mhtq_pkg::KIND_ADD, mhtq_pkg::KIND_ADJ, mhtq_pkg::KIND_FIRE: state <= S_LOOK;
              mhtq_pkg::KIND_TICK: begin
                now   <= now + 32'd1;
                state <= S_POP;
              end
              mhtq_pkg::KIND_QUERY: state <= S_POP;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOOK: state <= S_DISP;
        S_DISP: begin
          if (known && kind != mhtq_pkg::KIND_FIRE) begin
            // restart or adjust an existing timer
            cur   <= '{owner: tid, expiry: new_exp};
            i     <= sm_rd[SLOT_W-1:0];
            c     <= {1'b0, sm_rd[SLOT_W-1:0], 1'b1};
            moved <= 1'b0;
            state <= S_SD_RC;
          end else if (known) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_kind  <= mhtq_pkg::RK_EXPIRED;
              out_id    <= tid;
              out_rem   <= '0;
              out_last  <= 1'b1;
              i         <= sm_rd[SLOT_W-1:0];
              rid       <= tid;
              state     <= S_RM;
            end
          end else if (kind == mhtq_pkg::KIND_FIRE) begin
            state <= S_IDLE;
          end else if (kind == mhtq_pkg::KIND_ADJ || !in_range ||
                       count >= CNT_W'(CAPACITY)) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_kind  <= mhtq_pkg::RK_ERROR;
              out_id    <= '0;
              out_rem   <= '0;
              out_last  <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            // append a new timer and sift it up
            cur   <= '{owner: tid, expiry: new_exp};
            i     <= SLOT_W'(count);
            count <= count + CNT_W'(1);
            state <= S_SU;
          end
        end
        S_SD_RC: begin
          if (c < C_W'(count)) begin
            state <= S_SD_RC1;
          end else begin
            state <= moved ? S_PLACE : S_SU;
          end
        end
        S_SD_RC1: begin
          ch    <= hm_rd;
          state <= S_SD_CMP;
        end
        S_SD_CMP: begin
          if (sd_stop) begin
            state <= moved ? S_PLACE : S_SU;
          end else begin
            i     <= sel_idx;
            c     <= {1'b0, sel_idx, 1'b1};
            moved <= 1'b1;
            state <= S_SD_RC;
          end
        end
        S_SU: begin
          state <= (i == '0) ? S_PLACE : S_SU_CMP;
        end
        S_SU_CMP: begin
          if (su_stop) begin
            state <= S_PLACE;
          end else begin
            i     <= par;
            state <= S_SU;
          end
        end
        S_PLACE: state <= is_pop ? S_POP : S_IDLE;
        S_RM: begin
          count <= count - CNT_W'(1);
          if (CNT_W'(i) < count - CNT_W'(1)) begin
            state <= S_RM_RD;
          end else begin
            state <= is_pop ? S_POP : S_IDLE;
          end
        end
        S_RM_RD: state <= S_RM_LD;
        S_RM_LD: begin
          cur   <= hm_rd;
          c     <= {1'b0, i, 1'b1};
          moved <= 1'b0;
          state <= S_SD_RC;
        end
        S_POP: begin
          if (count != '0 && k < mhtq_pkg::POP_W'(mhtq_pkg::MAX_POP)) begin
            state <= S_POP_CHK;
          end else begin
            state <= S_FIN;
          end
        end
        S_POP_CHK: begin
          if (!due) begin
            state <= S_FIN;
          end else if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= mhtq_pkg::RK_EXPIRED;
            out_id    <= hm_rd.owner;
            out_rem   <= '0;
            out_last  <= 1'b0;
            k         <= k + mhtq_pkg::POP_W'(1);
            i         <= '0;
            rid       <= hm_rd.owner;
            state     <= S_RM;
          end
        end
        S_FIN: state <= S_FIN_EMIT;
        S_FIN_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_id    <= '0;
            out_last  <= 1'b1;
            if (kind == mhtq_pkg::KIND_TICK) begin
              out_kind <= mhtq_pkg::RK_DONE;
              out_rem  <= '0;
            end else begin
              out_kind <= mhtq_pkg::RK_DEADLINE;
              if (count == '0) begin
                out_rem <= mhtq_pkg::REM_NONE;
              end else if (d[mhtq_pkg::EXP_W-1]) begin
                out_rem <= '0;
              end else begin
                out_rem <= d;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `MHTQ_ASSERT_NOW(a_count_cap, 1'b1, count <= CNT_W'(CAPACITY), "heap count beyond capacity")
  `MHTQ_ASSERT_NEXT(a_busy_after_cmd, cmd_acc && (cmd.kind <= mhtq_pkg::KIND_QUERY), !cmd.ready, "ready again right after a command")
  `MHTQ_ASSERT_NEXT(a_count_step, 1'b1, count == $past(count) || count == $past(count) + CNT_W'(1) || count == $past(count) - CNT_W'(1), "heap count jumped")
  `MHTQ_ASSERT_NOW(a_quiet_clear, state == S_CLR, !out_valid, "result during clearing pass")

endmodule
